/* rtl/tpe_pkg.sv */
// Shared types and constants for the thick polyline expander.
// No dependencies.
`default_nettype none
package tpe_pkg;
    localparam int FracU  = 14;

    typedef enum logic {
        KIND_QUAD  = 1'b0,
        KIND_PATCH = 1'b1
    } kind_t;

    // datapath commands issued by the controller
    typedef struct packed {
        logic load_first;   // store point only
        logic load_seg;     // latch point, start segment math
        logic sqrt_start;
        logic div_start;    // start divide, div_sel picks numerator
        logic div_sel;      // 0: dy over len, 1: -dx over len
        logic calc_off;     // form offsets from quotients
        logic calc_vtx;     // form ceiled vertices
        logic commit;       // update prev and last_end state
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic have_point;
        logic past_first;
    } sts_t;
endpackage
`default_nettype wire

/* rtl/tpe_datapath.sv */
// Datapath: segment deltas, shared sqrt and divide unit, offsets, vertices.
// Depends on tpe_pkg.
`default_nettype none
module tpe_datapath #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tpe_pkg::cmd_t         cmd,
    output tpe_pkg::sts_t              sts,
    input  wire logic [COORD_WIDTH-1:0] px,
    input  wire logic [COORD_WIDTH-1:0] py,
    input  wire logic [COORD_WIDTH-1:0] pz,
    input  wire logic [7:0]            thickness,
    input  wire logic [2:0]            vsel,
    output logic [15:0]                vx,
    output logic [15:0]                vy
);
    import tpe_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;          // delta width
    localparam int PW  = 2 * DW;                   // square width
    localparam int SW  = 2 * DW + 2;               // sum of squares width
    localparam int RW  = (SW + 1) / 2;             // root width
    localparam int NW  = DW + FracU;               // numerator magnitude width
    localparam int CW  = COORD_WIDTH + 2;          // coordinate plus offset
    localparam int OW  = 24;                       // offset width (|off| <= 255*256+1)
    localparam int SQI = RW;                       // sqrt iterations
    localparam int CTW = $clog2(NW + 1) + 1;

    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [15:0] lex_reg, ley_reg;
    logic have_reg, past_reg;

    // square accumulate: one square per cycle
    logic [1:0]        sq_cnt_reg;
    logic [SW-1:0]     rem_reg;       // sqrt remainder / sum
    logic [RW-1:0]     root_reg;
    logic [CTW-1:0]    it_reg;
    logic              sq_busy_reg, sq_done_reg;
    logic signed [DW-1:0] sq_op;
    logic [PW-1:0]     sq_val;

    // sqrt working: rem_reg holds unprocessed pairs, acc holds partial remainder
    logic [RW+1:0]     sacc_reg;
    logic [RW+1:0]     sacc_sh;

    // divider
    logic [NW-1:0]     quo_reg;
    logic [RW:0]       drem_reg;
    logic              dv_busy_reg, dv_done_reg, dv_neg_reg;
    logic signed [FracU+2:0] ux_reg, uy_reg;
    logic signed [OW-1:0] offx_reg, offy_reg;
    logic [15:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg, e2x_reg, e2y_reg, e1x_reg, e1y_reg;

    logic [RW+1:0] trial;
    logic [RW:0]   dshift;
    logic [DW-1:0] dnum_mag;

    function automatic logic [15:0] ceil_sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        c = (v + CW'(255)) >>> 8;
        if (c > CW'(32767)) return 16'h7FFF;
        if (c < -CW'(32768)) return 16'h8000;
        return c[15:0];
    endfunction

    always_comb
    begin
        unique case (sq_cnt_reg)
            2'd0:    sq_op = dx_reg;
            2'd1:    sq_op = dy_reg;
            default: sq_op = dz_reg;
        endcase
        sq_val = $unsigned(PW'(sq_op) * PW'(sq_op));
    end

    // sqrt trial value, divider shift-in and numerator magnitude
    always_comb
    begin
        trial    = {root_reg, 2'b01};
        dshift   = {drem_reg[RW-1:0], quo_reg[NW-1]};
        if (cmd.div_sel)
            dnum_mag = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        else
            dnum_mag = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    end

    assign sacc_sh = {sacc_reg[RW-1:0], rem_reg[SW-1 -: 2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 1'b0;
            past_reg    <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_z_reg  <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_z_reg   <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            dz_reg      <= '0;
            lex_reg     <= '0;
            ley_reg     <= '0;
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_neg_reg  <= 1'b0;
            sq_cnt_reg  <= '0;
            rem_reg     <= '0;
            root_reg    <= '0;
            it_reg      <= '0;
            sacc_reg    <= '0;
            quo_reg     <= '0;
            drem_reg    <= '0;
            ux_reg      <= '0;
            uy_reg      <= '0;
            offx_reg    <= '0;
            offy_reg    <= '0;
            s1x_reg     <= '0;
            s1y_reg     <= '0;
            s2x_reg     <= '0;
            s2y_reg     <= '0;
            e2x_reg     <= '0;
            e2y_reg     <= '0;
            e1x_reg     <= '0;
            e1y_reg     <= '0;
        end
        else
        begin
            // one-cycle completion pulses
            sq_done_reg <= !cmd.sqrt_start && sq_busy_reg && (sq_cnt_reg == 2'd3)
                           && (it_reg == CTW'(SQI - 1));
            dv_done_reg <= !cmd.div_start && dv_busy_reg
                           && ((root_reg == '0) || (it_reg == CTW'(NW - 1)));
            if (cmd.load_first)
            begin
                prev_x_reg <= $signed(px);
                prev_y_reg <= $signed(py);
                prev_z_reg <= $signed(pz);
                have_reg   <= 1'b1;
                past_reg   <= 1'b0;
            end
            if (cmd.load_seg)
            begin
                cur_x_reg <= $signed(px);
                cur_y_reg <= $signed(py);
                cur_z_reg <= $signed(pz);
                dx_reg <= DW'($signed(px)) - DW'(prev_x_reg);
                dy_reg <= DW'($signed(py)) - DW'(prev_y_reg);
                dz_reg <= DW'($signed(pz)) - DW'(prev_z_reg);
            end
            // sum of squares, then root
            if (cmd.sqrt_start)
            begin
                sq_cnt_reg  <= 2'd0;
                rem_reg     <= '0;
                sq_busy_reg <= 1'b1;
                it_reg      <= '0;
                sacc_reg    <= '0;
                root_reg    <= '0;
            end
            else if (sq_busy_reg && sq_cnt_reg != 2'd3)
            begin
                rem_reg    <= rem_reg + SW'(sq_val);
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
            end
            else if (sq_busy_reg)
            begin
                rem_reg <= rem_reg << 2;
                if (sacc_sh >= trial)
                begin
                    sacc_reg <= sacc_sh - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    sacc_reg <= sacc_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                it_reg <= it_reg + CTW'(1);
                if (it_reg == CTW'(SQI - 1))
                    sq_busy_reg <= 1'b0;
            end
            // restoring divide, one quotient bit per cycle
            if (cmd.div_start)
            begin
                dv_neg_reg  <= cmd.div_sel;
                dv_busy_reg <= 1'b1;
                it_reg      <= '0;
                drem_reg    <= '0;
                quo_reg     <= {dnum_mag, {FracU{1'b0}}};
            end
            else if (dv_busy_reg)
            begin
                if (root_reg == '0)
                begin
                    quo_reg     <= '0;
                    dv_busy_reg <= 1'b0;
                end
                else
                begin
                    if (dshift >= {1'b0, root_reg})
                    begin
                        drem_reg <= dshift - {1'b0, root_reg};
                        quo_reg  <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dshift;
                        quo_reg  <= {quo_reg[NW-2:0], 1'b0};
                    end
                    it_reg <= it_reg + CTW'(1);
                    if (it_reg == CTW'(NW - 1))
                        dv_busy_reg <= 1'b0;
                end
            end
            if (dv_done_reg)
            begin
                // quotient fits in 14+1 bits, sign from numerator
                if (!dv_neg_reg)
                    ux_reg <= dy_reg[DW-1] ? -$signed({2'b00, quo_reg[FracU:0]})
                                           : $signed({2'b00, quo_reg[FracU:0]});
                else
                    uy_reg <= dx_reg[DW-1] ? $signed({2'b00, quo_reg[FracU:0]})
                                           : -$signed({2'b00, quo_reg[FracU:0]});
            end
            if (cmd.calc_off)
            begin
                offx_reg <= (OW'(ux_reg) * $signed({1'b0, thickness}) + OW'(32)) >>> 6;
                offy_reg <= (OW'(uy_reg) * $signed({1'b0, thickness}) + OW'(32)) >>> 6;
            end
            if (cmd.calc_vtx)
            begin
                s1x_reg <= ceil_sat(CW'(prev_x_reg));
                s1y_reg <= ceil_sat(CW'(prev_y_reg));
                s2x_reg <= ceil_sat(CW'(prev_x_reg) + CW'(offx_reg));
                s2y_reg <= ceil_sat(CW'(prev_y_reg) + CW'(offy_reg));
                e2x_reg <= ceil_sat(CW'(cur_x_reg) + CW'(offx_reg));
                e2y_reg <= ceil_sat(CW'(cur_y_reg) + CW'(offy_reg));
                e1x_reg <= ceil_sat(CW'(cur_x_reg));
                e1y_reg <= ceil_sat(CW'(cur_y_reg));
            end
            if (cmd.commit)
            begin
                lex_reg    <= e2x_reg;
                ley_reg    <= e2y_reg;
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_z_reg <= cur_z_reg;
                past_reg   <= 1'b1;
            end
        end
    end

    // vertex select for the output stage
    always_comb
    begin
        case (vsel) inside
            3'd0, 3'd4: begin vx = s1x_reg; vy = s1y_reg; end
            3'd1, 3'd5: begin vx = s2x_reg; vy = s2y_reg; end
            3'd2:       begin vx = e2x_reg; vy = e2y_reg; end
            3'd3:       begin vx = e1x_reg; vy = e1y_reg; end
            default:    begin vx = lex_reg; vy = ley_reg; end
        endcase
    end

    assign sts = {sq_done_reg, dv_done_reg, have_reg, past_reg};
endmodule
`default_nettype wire

/* rtl/tpe_ctrl.sv */
// Controller: sequences sqrt, two divides, offsets and vertex emission.
// Depends on tpe_pkg.
`default_nettype none
module tpe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          new_line,
    input  wire tpe_pkg::sts_t sts,
    output tpe_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         vsel,
    output logic               vlast
);
    import tpe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_DIVX, S_DIVY, S_OFF, S_VTX, S_EMIT, S_DONE
    } state_t;

    state_t     state_reg;
    logic [2:0] vsel_reg;
    logic       past_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign vsel      = vsel_reg;
    assign vlast     = past_reg ? (vsel_reg == 3'd6) : (vsel_reg == 3'd3);

    always_comb
    begin
        cmd = '0;
        cmd.load_first = in_fire && (new_line || !sts.have_point);
        cmd.load_seg   = in_fire && !(new_line || !sts.have_point);
        cmd.sqrt_start = cmd.load_seg;
        cmd.div_sel    = (state_reg == S_DIVY);
        cmd.calc_off   = (state_reg == S_OFF);
        cmd.calc_vtx   = (state_reg == S_VTX);
        cmd.commit     = (state_reg == S_DONE);
        cmd.div_start  = (state_reg == S_SQRT && sts.sqrt_done)
                      || (state_reg == S_DIVX && sts.div_done);
        if (state_reg == S_DIVX && sts.div_done)
            cmd.div_sel = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vsel_reg  <= '0;
            past_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (cmd.load_seg) state_reg <= S_SQRT;
                S_SQRT: if (sts.sqrt_done) state_reg <= S_DIVX;
                S_DIVX: if (sts.div_done) state_reg <= S_DIVY;
                S_DIVY: if (sts.div_done) state_reg <= S_OFF;
                S_OFF:  state_reg <= S_VTX;
                S_VTX:
                begin
                    state_reg <= S_EMIT;
                    vsel_reg  <= '0;
                    past_reg  <= sts.past_first;
                end
                S_EMIT:
                    if (out_ready)
                    begin
                        if (vlast) state_reg <= S_DONE;
                        else vsel_reg <= vsel_reg + 3'd1;
                    end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_vsel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vsel_reg <= 3'd6)) else $error("vertex index out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (state_reg == S_IDLE)) else $error("commit not followed by idle");
endmodule
`default_nettype wire

/* rtl/thick_polyline_expander.sv */
// Top level of the thick polyline expander: controller plus datapath.
// Depends on tpe_pkg, tpe_ctrl, tpe_datapath.
//
//  channel | dir | contents
//  s_axis  | in  | tdata point_x,y,z ; tuser new_line
//  m_axis  | out | tdata vertex_x,y,corner,kind ; tlast last
//  cfg     | in  | thickness
// A segment passes through the accept, the sum of 3 squares, COORD_WIDTH+2 root
// steps and a handoff, two divides on the shared bit-serial unit, offset and
// vertex setup, 4 or 7 beats, a commit and a return to idle between accepts.
// A first point is only stored. Reset clears state; thickness resets to 1.
// A stalled m_axis holds the vertex beat; no input is taken meanwhile.
`default_nettype none
module thick_polyline_expander #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // point_x, point_y, point_z from bit 0
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // new_line
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // vertex_x, vertex_y, corner, shape_kind from bit 0, zero fill
    output logic [39:0] m_axis_tdata,
    output logic      m_axis_tlast,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [7:0] cfg_data
);
    import tpe_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [7:0] thick_reg;
    logic [2:0] vsel;
    logic       vlast, in_fire;
    logic [15:0] vx, vy;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thick_reg <= 8'd1;
        else if (cfg_valid) thick_reg <= cfg_data;
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    tpe_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .new_line(s_axis_tuser),
        .sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .vsel(vsel), .vlast(vlast)
    );

    tpe_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .px(s_axis_tdata[COORD_WIDTH-1:0]),
        .py(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .pz(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .thickness(thick_reg), .vsel(vsel), .vx(vx), .vy(vy)
    );

    assign m_axis_tdata = {5'd0, (vsel > 3'd3) ? KIND_PATCH : KIND_QUAD,
                           (vsel > 3'd3) ? 2'(vsel - 3'd4) : vsel[1:0], vy, vx};
    assign m_axis_tlast = vlast;
endmodule
`default_nettype wire
